@@ rtl/ows_pkg.sv @@
`default_nettype none

package ows_pkg;

   // Number of ROM bytes taken part in the search, and the bits that follow from it.
   localparam int IdBytes = 8;
   localparam int RawBits = IdBytes * 8;
   localparam int NumBits = (RawBits < 8) ? 8 : ((RawBits > 64) ? 64 : RawBits);

   // Bit positions run from one up to the last ROM bit.
   localparam logic [6:0] FIRST_BIT = 7'd1;
   localparam logic [6:0] LAST_BIT  = 7'(NumBits);

   // Discrepancies at positions below this one lie inside the family byte.
   localparam logic [6:0] FAMILY_LIMIT = 7'd9;

   // Bits of the ROM that the search really fills.
   localparam logic [63:0] ROM_MASK = (NumBits >= 64) ? {64{1'b1}} :
                                      ((64'd1 << NumBits) - 64'd1);

   typedef enum logic [1:0] {
      MODE_FIRST   = 2'd0,
      MODE_NEXT    = 2'd1,
      MODE_RESULT  = 2'd2,
      MODE_TRIPLET = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_RESET   = 2'd0,
      ACT_TRIPLET = 2'd1,
      ACT_FOUND   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_RESET  = 2'd1,
      PH_SEARCH = 2'd2
   } phase_type;

   // Search memory and progress of the running search.
   typedef struct packed {
      logic [63:0] rom_bits;
      logic [6:0]  last_disc;
      logic [3:0]  last_fam_disc;
      logic        last_dev;
      logic [6:0]  zero_branch;
      logic [6:0]  bit_pos;
      phase_type   phase;
   } srch_state_type;

   // One result item.
   typedef struct packed {
      action_type  action;
      logic        direction;
      logic [63:0] rom_code;
      logic        last_device;
      logic [3:0]  family_disc;
   } rsp_item_type;

   // Preferred direction at a bit position: follow the previous ROM below the
   // last discrepancy, take the one branch at it, and the zero branch above it.
   function automatic logic pick_dir(input logic [6:0]  bit_pos,
                                     input logic [6:0]  last_disc,
                                     input logic [63:0] rom_bits);
      logic [6:0] idx_full;
      logic       dir;
      idx_full = bit_pos - 7'd1;
      if (bit_pos < last_disc) begin
         dir = rom_bits[idx_full[5:0]];
      end else begin
         dir = (bit_pos == last_disc);
      end
      return dir;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ows_step.sv @@
`default_nettype none

module ows_step (
   input  ows_pkg::srch_state_type cur_state,
   input  ows_pkg::mode_type       mode,
   input  logic                    presence,
   input  logic                    id_bit,
   input  logic                    complement_bit,
   input  logic                    taken_direction,
   output ows_pkg::srch_state_type nxt_state,
   output ows_pkg::rsp_item_type   rsp_item
);
   import ows_pkg::*;

   // Next state and result for one event.
   always_comb begin
      srch_state_type nxt;
      rsp_item_type   res;
      logic [6:0]     idx_full;
      logic [6:0]     next_pos;
      logic           in_range;

      nxt      = cur_state;
      res      = '0;
      res.action = ACT_NONE;
      idx_full = cur_state.bit_pos - 7'd1;
      next_pos = cur_state.bit_pos + 7'd1;
      in_range = (cur_state.bit_pos >= FIRST_BIT) && (cur_state.bit_pos <= LAST_BIT);

      unique case (mode) inside
         MODE_FIRST, MODE_NEXT: begin
            nxt.bit_pos     = FIRST_BIT;
            nxt.zero_branch = '0;
            if (mode == MODE_NEXT && cur_state.last_dev) begin
               // The previous search already found the last device.
               nxt.last_disc     = '0;
               nxt.last_fam_disc = '0;
               nxt.last_dev      = 1'b0;
               nxt.phase         = PH_IDLE;
            end else begin
               if (mode == MODE_FIRST) begin
                  nxt.last_disc     = '0;
                  nxt.last_fam_disc = '0;
                  nxt.last_dev      = 1'b0;
               end
               nxt.phase  = PH_RESET;
               res.action = ACT_RESET;
            end
         end
         MODE_RESULT: begin
            if (cur_state.phase == PH_RESET) begin
               if (!presence) begin
                  nxt.last_disc     = '0;
                  nxt.last_fam_disc = '0;
                  nxt.last_dev      = 1'b0;
                  nxt.phase         = PH_IDLE;
               end else begin
                  nxt.phase     = PH_SEARCH;
                  res.action    = ACT_TRIPLET;
                  res.direction = pick_dir(cur_state.bit_pos, cur_state.last_disc,
                                           cur_state.rom_bits);
               end
            end
         end
         MODE_TRIPLET: begin
            if (cur_state.phase == PH_SEARCH && in_range) begin
               if (id_bit && complement_bit) begin
                  // Nobody answered: the search fails.
                  nxt.last_disc     = '0;
                  nxt.last_fam_disc = '0;
                  nxt.last_dev      = 1'b0;
                  nxt.phase         = PH_IDLE;
               end else begin
                  // A discrepancy resolved toward zero is remembered.
                  if (!id_bit && !complement_bit && !taken_direction) begin
                     nxt.zero_branch = cur_state.bit_pos;
                     if (cur_state.bit_pos < FAMILY_LIMIT) begin
                        nxt.last_fam_disc = cur_state.bit_pos[3:0];
                     end
                  end
                  nxt.rom_bits[idx_full[5:0]] = taken_direction;
                  nxt.bit_pos = next_pos;
                  if (cur_state.bit_pos < LAST_BIT) begin
                     res.action    = ACT_TRIPLET;
                     res.direction = pick_dir(next_pos, cur_state.last_disc,
                                              nxt.rom_bits);
                  end else begin
                     // Last bit done: close the search.
                     nxt.phase     = PH_IDLE;
                     nxt.last_disc = nxt.zero_branch;
                     if (nxt.zero_branch == 7'd0) begin
                        nxt.last_dev = 1'b1;
                     end
                     if (nxt.rom_bits[7:0] == 8'd0) begin
                        // A zero family byte counts as a failed search.
                        nxt.last_disc     = '0;
                        nxt.last_fam_disc = '0;
                        nxt.last_dev      = 1'b0;
                     end else begin
                        res.action      = ACT_FOUND;
                        res.rom_code    = nxt.rom_bits & ROM_MASK;
                        res.last_device = nxt.last_dev;
                        res.family_disc = nxt.last_fam_disc;
                     end
                  end
               end
            end
         end
         default: begin
            nxt = cur_state;
         end
      endcase

      nxt_state = nxt;
      rsp_item  = res;
   end

endmodule

`default_nettype wire

@@ rtl/onewire_rom_search_engine_core.sv @@
`default_nettype none

// ROM search engine for a 1-Wire bus master. The host sends one event per
// item (start first search, start next search, bus reset result, triplet
// result) and gets exactly one result item back: issue a reset and search
// command, issue a triplet with the given preferred direction, device found
// with its ROM, or no device / search over. The engine takes one item every
// clock cycle: the search state and the result register are both updated in
// the cycle the item is accepted, and the result register is the only stage,
// so a new item is taken whenever the result register is empty or being
// drained in that cycle. A valid result appears in the cycle after acceptance.
module onewire_rom_search_engine_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ows_pkg::mode_type      req_mode,
   input  logic                   req_presence,
   input  logic                   req_id_bit,
   input  logic                   req_complement_bit,
   input  logic                   req_taken_direction,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ows_pkg::action_type    rsp_action,
   output logic                   rsp_direction,
   output logic [63:0]            rsp_rom_code,
   output logic                   rsp_last_device,
   output logic [3:0]             rsp_family_discrepancy
);
   import ows_pkg::*;

   srch_state_type state_ff;
   srch_state_type state_in;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   rsp_item_in;
   logic           rsp_valid_ff;
   logic           req_accept;

   // Next state and result for the event at the input.
   ows_step u_step (
      .cur_state       (state_ff),
      .mode            (req_mode),
      .presence        (req_presence),
      .id_bit          (req_id_bit),
      .complement_bit  (req_complement_bit),
      .taken_direction (req_taken_direction),
      .nxt_state       (state_in),
      .rsp_item        (rsp_item_in)
   );

   // An item enters whenever the result register frees up in this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Search state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bits      <= '0;
         state_ff.last_disc     <= '0;
         state_ff.last_fam_disc <= '0;
         state_ff.last_dev      <= 1'b0;
         state_ff.zero_branch   <= '0;
         state_ff.bit_pos       <= FIRST_BIT;
         state_ff.phase         <= PH_IDLE;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_action             = rsp_item_ff.action;
   assign rsp_direction          = rsp_item_ff.direction;
   assign rsp_rom_code           = rsp_item_ff.rom_code;
   assign rsp_last_device        = rsp_item_ff.last_device;
   assign rsp_family_discrepancy = rsp_item_ff.family_disc;

`ifndef ASSERT_OFF
   // Every accepted item yields a result in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item produced no result");

   // Only a found device carries ROM and device fields.
   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_FOUND |->
         rsp_rom_code == 64'd0 && !rsp_last_device && rsp_family_discrepancy == 4'd0)
      else $error("result fields set without a found device");

   // While searching, the bit position stays inside the ROM.
   a_search_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_SEARCH |->
         state_ff.bit_pos >= FIRST_BIT && state_ff.bit_pos <= LAST_BIT)
      else $error("bit position out of range during search");

   // The family discrepancy never points past the family byte.
   a_family_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.last_fam_disc <= FAMILY_LIMIT[3:0] - 4'd1)
      else $error("family discrepancy out of range");
`endif

endmodule

`default_nettype wire
